[rtl/core/flq_pkg.sv]
// ----------------------------------------------------------------------------
// flq_pkg
// Types and constants shared by the FIFO/LIFO queue controller, datapath and
// top level.
// ----------------------------------------------------------------------------
package flq_pkg;

   localparam int DEPTH_DEF      = 16;
   localparam int DATA_WIDTH_DEF = 32;

   // Widths fixed by the beat format.
   localparam int WORD_W  = 32;
   localparam int COUNT_W = 5;
   // Widest word the store may be built with.
   localparam int WIDE_W  = 64;

   localparam logic MODE_FIFO = 1'b0;
   localparam logic MODE_LIFO = 1'b1;

   typedef enum logic [0:0] {
      CMD_PUSH = 1'b0,
      CMD_POP  = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type             cmd;
      logic [WORD_W-1:0]   push_data;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0]   pop_data;
      logic                pop_valid;
      logic                push_dropped;
      logic [COUNT_W-1:0]  item_count;
      logic                has_items;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_PUSH,
      OP_DROP,
      OP_POP_FIFO,
      OP_POP_LIFO,
      OP_POP_EMPTY
   } op_type;

   // Controller to datapath.
   typedef struct packed {
      op_type op;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic full;
      logic empty;
   } dp_status_type;

endpackage

[rtl/core/flq_ctrl.sv]
// ----------------------------------------------------------------------------
// flq_ctrl
// Sequencer for the queue: holds the mode register, decodes each accepted
// beat into a datapath operation and strobes the result in the cycle after.
// ----------------------------------------------------------------------------
module flq_ctrl
   import flq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  cmd_type       req_cmd,
   input  logic          csr_we,
   input  logic          csr_wdata,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_valid
);

   state_type state_ff, state_in;
   logic      mode_ff, mode_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= MODE_FIFO;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
      end
   end

   assign mode_in = csr_we ? csr_wdata : mode_ff;

   always_comb begin
      state_in  = state_ff;
      cmd.op    = OP_IDLE;
      busy      = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_RESP;
               if (req_cmd == CMD_PUSH) begin
                  cmd.op = status.full ? OP_DROP : OP_PUSH;
               end else if (status.empty) begin
                  cmd.op = OP_POP_EMPTY;
               end else begin
                  cmd.op = (mode_ff == MODE_LIFO) ? OP_POP_LIFO : OP_POP_FIFO;
               end
            end
         end
         ST_RESP: begin
            // The slot read issued on accept lands now, so the result goes out.
            busy      = 1'b1;
            rsp_valid = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[rtl/core/flq_datapath.sv]
// ----------------------------------------------------------------------------
// flq_datapath
// Slot ring, oldest-slot pointer, word count and the result registers.
// ----------------------------------------------------------------------------
module flq_datapath
   import flq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
   input  logic              clock,
   input  logic              reset,
   input  ctrl_cmd_type      cmd,
   input  logic [WORD_W-1:0] push_data,
   output dp_status_type     status,
   output rsp_type           rsp_item
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W:0]   DEPTH_SUM = (IDX_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [DATA_WIDTH-1:0] slot_mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [IDX_W-1:0]      oldest_ff, oldest_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  pop_valid_ff;
   logic                  push_dropped_ff;

   logic [IDX_W-1:0]      push_addr;
   logic [IDX_W-1:0]      newest_addr;
   logic [IDX_W-1:0]      rd_addr;
   logic [WIDE_W-1:0]     push_wide;
   logic [WIDE_W-1:0]     rd_wide;
   logic                  is_pop;

   // Both operands stay below DEPTH, so one compare and subtract wraps the sum.
   function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] offs);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return sum[IDX_W-1:0];
   endfunction

   assign push_addr   = ring_add(oldest_ff, IDX_W'(count_ff));
   assign newest_addr = ring_add(oldest_ff, IDX_W'(count_ff - CNT_W'(1)));
   assign rd_addr     = (cmd.op == OP_POP_LIFO) ? newest_addr : oldest_ff;
   assign is_pop      = (cmd.op == OP_POP_FIFO) || (cmd.op == OP_POP_LIFO);
   assign push_wide   = WIDE_W'(push_data);

   assign status.full  = (count_ff == DEPTH_CNT);
   assign status.empty = (count_ff == '0);

   always_comb begin
      oldest_in = oldest_ff;
      count_in  = count_ff;
      case (cmd.op)
         OP_PUSH: begin
            count_in = count_ff + CNT_W'(1);
         end
         OP_POP_FIFO: begin
            oldest_in = ring_add(oldest_ff, IDX_W'(1));
            count_in  = count_ff - CNT_W'(1);
         end
         OP_POP_LIFO: begin
            count_in = count_ff - CNT_W'(1);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff <= '0;
         count_ff  <= '0;
      end else begin
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUSH) begin
         slot_mem[push_addr] <= push_wide[DATA_WIDTH-1:0];
      end
      if (is_pop) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op != OP_IDLE) begin
         pop_valid_ff    <= is_pop;
         push_dropped_ff <= (cmd.op == OP_DROP);
      end
   end

   assign rd_wide = WIDE_W'(rd_data_ff);

   assign rsp_item.pop_data     = pop_valid_ff ? rd_wide[WORD_W-1:0] : '0;
   assign rsp_item.pop_valid    = pop_valid_ff;
   assign rsp_item.push_dropped = push_dropped_ff;
   assign rsp_item.item_count   = COUNT_W'(count_ff);
   assign rsp_item.has_items    = (count_ff != '0);

endmodule

[rtl/core/fifo_lifo_queue_core.sv]
// ----------------------------------------------------------------------------
// fifo_lifo_queue_core
// Bounded word store that works as a FIFO queue or a LIFO stack.
// ----------------------------------------------------------------------------
// A beat is accepted when start is high and busy is low; it is a push of
// req_item.push_data or a pop. Each beat gives exactly one result, strobed by
// rsp_valid for a single cycle in the cycle after acceptance, and the receiver
// cannot hold it off. busy is high during that result cycle, so the next beat
// waits until the result is out: the slot memory has a registered read, and
// its data lands in the cycle after the address is formed. csr_wdata written
// with csr_we selects the mode (0 FIFO, 1 LIFO); write it only while no beat
// is outstanding. Words held are kept across a mode change. A pop on an empty
// store returns zero with pop_valid low; a push on a full store is dropped and
// flagged with push_dropped. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module fifo_lifo_queue_core
   import flq_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item,
   input  logic    csr_we,
   input  logic    csr_wdata
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   flq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_item.cmd),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   flq_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .push_data (req_item.push_data),
      .status    (status),
      .rsp_item  (rsp_item)
   );

`ifndef SYNTH
   // Every accepted beat produces its result in the very next cycle.
   a_rsp_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted beat gave no result");

   // A result occupies one cycle only.
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobed on consecutive cycles");

   // A beat is either a push or a pop, never both outcomes.
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.pop_valid && rsp_item.push_dropped))
      else $error("pop_valid and push_dropped both set");
`endif

endmodule
